FILE: design/lkvc_pkg.sv
`default_nettype none
package lkvc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int AGE_W      = 4;
	localparam int CNT_W      = 5;
	localparam int CAP_W      = 5;
	localparam int OP_W       = 2;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} lkvc_cmd_t;

endpackage
`default_nettype wire

FILE: design/lkvc_ctrl.sv
`default_nettype none
module lkvc_ctrl
	import lkvc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_axis_tvalid,
	output logic       s_axis_tready,
	output logic       m_axis_tvalid,
	input  wire logic  m_axis_tready,
	output lkvc_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// wait until the result slot is free
				if (!out_valid_q || m_axis_tready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/lkvc_dp.sv
`default_nettype none
module lkvc_dp
	import lkvc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lkvc_cmd_t             cmd,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic [OP_W-1:0]       s_axis_tuser,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                       m_axis_tuser,
	input  wire logic                  cfg_valid,
	input  wire logic [CAP_W-1:0]      cfg_data
);

	logic [ENTRIES-1:0]    valid_q;
	logic [KEY_BITS-1:0]   ekey_q [ENTRIES];
	logic [VALUE_BITS-1:0] edata_q [ENTRIES];
	logic [AGE_W-1:0]      age_q [ENTRIES];
	logic [CNT_W-1:0]      count_q;
	logic [CAP_W-1:0]      capacity_q;

	logic [OP_W-1:0]       op_q;
	logic [KEY_BITS-1:0]   req_key_q;
	logic [VALUE_BITS-1:0] req_val_q;
	logic [ENTRIES-1:0]    hit_q;

	logic                  found_q;
	logic                  evicted_q;
	logic [VALUE_BITS-1:0] rd_value_q;

	logic [KEY_BITS-1:0]   in_key;
	logic [ENTRIES-1:0]    match;
	logic                  hit;
	logic [AGE_W-1:0]      hit_age;
	logic [VALUE_BITS-1:0] hit_data;
	logic [CNT_W-1:0]      cap_eff;
	logic [CNT_W-1:0]      count_m1;
	logic                  op_valid;
	logic                  do_evict;
	logic [ENTRIES-1:0]    oldest;
	logic [ENTRIES-1:0]    valid_after;
	logic [ENTRIES-1:0]    free_oh;

	assign in_key = s_axis_tdata[KEY_BITS-1:0];

	// key compare across all entries, registered at request capture
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (ekey_q[i] == in_key);
		end
	end

	always_comb begin
		hit      = |hit_q;
		hit_age  = '0;
		hit_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_q[i]) begin
				hit_age  = hit_age | age_q[i];
				hit_data = hit_data | edata_q[i];
			end
		end
		if (capacity_q > CAP_W'(ENTRIES)) begin
			cap_eff = CNT_W'(ENTRIES);
		end else if (capacity_q == '0) begin
			cap_eff = CNT_W'(1);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
		count_m1 = count_q - CNT_W'(1);
		op_valid = (op_q == OP_PUT) || (op_q == OP_GET) || (op_q == OP_REMOVE);
		do_evict = (op_q == OP_PUT) && !hit && (count_q >= cap_eff);
		// ages of valid entries are 0..count-1, so the oldest holds count-1
		for (int i = 0; i < ENTRIES; i++) begin
			oldest[i] = valid_q[i] && ({1'b0, age_q[i]} == count_m1);
		end
		valid_after = do_evict ? (valid_q & ~oldest) : valid_q;
		// lowest clear bit
		free_oh = ~valid_after & (valid_after + ENTRIES'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			count_q    <= '0;
			capacity_q <= CAP_RESET;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			if (cmd.commit) begin
				case (op_q)
					OP_PUT: begin
						if (hit) begin
							for (int i = 0; i < ENTRIES; i++) begin
								if (hit_q[i]) begin
									age_q[i] <= '0;
								end else if (valid_q[i] && age_q[i] < hit_age) begin
									age_q[i] <= age_q[i] + AGE_W'(1);
								end
							end
						end else begin
							for (int i = 0; i < ENTRIES; i++) begin
								if (free_oh[i]) begin
									valid_q[i] <= 1'b1;
									age_q[i]   <= '0;
								end else if (valid_after[i]) begin
									age_q[i] <= age_q[i] + AGE_W'(1);
								end else if (valid_q[i]) begin
									valid_q[i] <= 1'b0;
									age_q[i]   <= '0;
								end
							end
							if (!do_evict) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
					end
					OP_GET: begin
						if (hit) begin
							for (int i = 0; i < ENTRIES; i++) begin
								if (hit_q[i]) begin
									age_q[i] <= '0;
								end else if (valid_q[i] && age_q[i] < hit_age) begin
									age_q[i] <= age_q[i] + AGE_W'(1);
								end
							end
						end
					end
					OP_REMOVE: begin
						if (hit) begin
							for (int i = 0; i < ENTRIES; i++) begin
								if (hit_q[i]) begin
									valid_q[i] <= 1'b0;
									age_q[i]   <= '0;
								end else if (valid_q[i] && age_q[i] > hit_age) begin
									age_q[i] <= age_q[i] - AGE_W'(1);
								end
							end
							if (count_q != '0) begin
								count_q <= count_m1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload: request, entry contents and result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= s_axis_tuser;
			req_key_q <= in_key;
			req_val_q <= s_axis_tdata[KEY_BITS +: VALUE_BITS];
			hit_q     <= match;
		end
		if (cmd.commit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (op_q == OP_PUT && hit_q[i]) begin
					edata_q[i] <= req_val_q;
				end else if (op_q == OP_PUT && !hit && free_oh[i]) begin
					ekey_q[i]  <= req_key_q;
					edata_q[i] <= req_val_q;
				end
			end
			found_q    <= op_valid && hit;
			evicted_q  <= do_evict;
			rd_value_q <= (op_q == OP_GET && hit) ? hit_data : '0;
		end
	end

	assign m_axis_tuser = found_q;
	assign m_axis_tdata = {(OUT_DATA_W - VALUE_BITS - 1)'(0), evicted_q, rd_value_q};

endmodule
`default_nettype wire

FILE: design/lru_key_value_cache_unit.sv
// channel   | handshake             | payload (lowest bit first)
// ----------+-----------------------+---------------------------------------------
// request   | s_axis_tvalid/tready  | tdata: key[31:0], value[63:32]; tuser: operation
// result    | m_axis_tvalid/tready  | tdata: read_value[31:0], evicted[32]; tuser: found
// config    | cfg_valid/cfg_ready   | cfg_data: capacity
//
// A request is captured in the idle state, which registers the key compare against all
// entries; the execute state then updates ages, valid bits and entries and loads the result.
// A result register decouples the sides; a request is taken while a result waits,
// and its update holds until that result is taken. Requests are only taken in the idle state.
// Reset clears all valid bits, ages and the count; capacity resets to 16.
`default_nettype none
module lru_key_value_cache_unit
	import lkvc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,  // key, value
	input  wire logic [OP_W-1:0]        s_axis_tuser,  // operation
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]       m_axis_tdata,  // read_value, evicted, zero pad
	output logic                        m_axis_tuser,  // found
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CAP_W-1:0]       cfg_data
);

	lkvc_cmd_t cmd;

	assign cfg_ready = 1'b1;

	lkvc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd)
	);

	lkvc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data)
	);

endmodule
`default_nettype wire

FILE: sim/tb_lru_key_value_cache_unit.sv
`default_nettype none
module tb_lru_key_value_cache_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lkvc_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [OP_W-1:0]       op;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} cache_req_t;

	typedef struct {
		logic                  found;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
	} cache_resp_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CAP_W-1:0]      cfg_data = '0;

	lru_key_value_cache_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// shadow copy of the cache contents
	logic                  shadow_valid [ENTRIES];
	logic [KEY_BITS-1:0]   shadow_key [ENTRIES];
	logic [VALUE_BITS-1:0] shadow_data [ENTRIES];
	int                    shadow_age [ENTRIES];
	int                    shadow_count;
	logic [CAP_W-1:0]      shadow_capacity;

	cache_req_t  pending_requests [$];
	cache_resp_t expected_responses [$];
	int          fail_count = 0;
	int          idle_odds = 0;      // 0: no idling, else one chance in idle_odds
	int          hold_requests = 0;

	function automatic void promote_entry(int s);
		int a;
		a = shadow_age[s];
		for (int i = 0; i < ENTRIES; i++)
			if (shadow_valid[i] && shadow_age[i] < a)
				shadow_age[i]++;
		shadow_age[s] = 0;
	endfunction

	function automatic void drop_entry(int s);
		int a;
		a = shadow_age[s];
		shadow_valid[s] = 1'b0;
		shadow_age[s] = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (shadow_valid[i] && shadow_age[i] > a)
				shadow_age[i]--;
		if (shadow_count > 0)
			shadow_count--;
	endfunction

	function automatic cache_resp_t lookup_and_update(cache_req_t r);
		cache_resp_t res;
		int slot;
		int oldest;
		int eff_cap;
		res = '{1'b0, '0, 1'b0};
		if (r.op == OP_UNUSED)
			return res;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && shadow_valid[i] && shadow_key[i] == r.key)
				slot = i;
		res.found = (slot >= 0);
		if (r.op == OP_PUT) begin
			if (slot >= 0) begin
				shadow_data[slot] = r.value;
				promote_entry(slot);
			end else begin
				eff_cap = (shadow_capacity > ENTRIES) ? ENTRIES : int'(shadow_capacity);
				if (eff_cap == 0)
					eff_cap = 1;
				if (shadow_count >= eff_cap) begin
					oldest = -1;
					for (int i = 0; i < ENTRIES; i++)
						if (shadow_valid[i] && (oldest < 0 || shadow_age[i] > shadow_age[oldest]))
							oldest = i;
					if (oldest >= 0) begin
						drop_entry(oldest);
						res.evicted = 1'b1;
					end
				end
				for (int i = 0; i < ENTRIES; i++)
					if (shadow_valid[i])
						shadow_age[i]++;
				for (int i = 0; i < ENTRIES; i++) begin
					if (!shadow_valid[i]) begin
						shadow_valid[i] = 1'b1;
						shadow_key[i] = r.key;
						shadow_data[i] = r.value;
						shadow_age[i] = 0;
						shadow_count++;
						break;
					end
				end
			end
		end else if (r.op == OP_GET) begin
			if (slot >= 0) begin
				promote_entry(slot);
				res.read_value = shadow_data[slot];
			end
		end else if (slot >= 0) begin
			drop_entry(slot);
		end
		return res;
	endfunction

	// request driver
	cache_req_t drv_req;
	logic       drv_busy = 1'b0;
	int         drv_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			drv_busy = 1'b0;
			drv_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_responses.push_back(lookup_and_update(drv_req));
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (drv_gap > 0) begin
					drv_gap--;
				end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
					drv_gap = $urandom_range(1, 9) - 1;
				end else if (pending_requests.size() != 0) begin
					drv_req = pending_requests.pop_front();
					drv_busy = 1'b1;
				end
			end
			s_axis_tvalid <= drv_busy;
			if (drv_busy) begin
				s_axis_tdata <= {drv_req.value, drv_req.key};
				s_axis_tuser <= drv_req.op;
			end
		end
	end

	// result monitor and receiver
	cache_resp_t mon_exp;
	int          rcv_gap = 0;
	int          hold_left = 0;
	int          hold_seen = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_responses.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					mon_exp = expected_responses.pop_front();
					if (m_axis_tuser !== mon_exp.found) begin
						$error("found: expected %0d, got %0d", mon_exp.found, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata[31:0] !== mon_exp.read_value) begin
						$error("read_value: expected %h, got %h", mon_exp.read_value,
							m_axis_tdata[31:0]);
						fail_count++;
					end
					if (m_axis_tdata[32] !== mon_exp.evicted) begin
						$error("evicted: expected %0d, got %0d", mon_exp.evicted,
							m_axis_tdata[32]);
						fail_count++;
					end
				end
			end
			if (hold_seen != hold_requests) begin
				hold_seen++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rcv_gap > 0) begin
				rcv_gap--;
				m_axis_tready <= 1'b0;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				rcv_gap = $urandom_range(1, 9) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic queue_request(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
		logic [VALUE_BITS-1:0] value);
		cache_req_t r;
		r.op = op;
		r.key = key;
		r.value = value;
		pending_requests.push_back(r);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_requests.size() != 0 || s_axis_tvalid || drv_busy
			|| expected_responses.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		shadow_capacity = cap;
	endtask

	task automatic random_phase(logic [CAP_W-1:0] cap, int n_items);
		logic [KEY_BITS-1:0] key_pool [$];
		logic [KEY_BITS-1:0] k;
		int pool_size;
		int pick;
		logic [OP_W-1:0] op;
		write_capacity(cap);
		pool_size = ((cap > ENTRIES) ? ENTRIES : int'(cap)) + 3;
		for (int i = 0; i < pool_size; i++)
			key_pool.push_back($urandom());
		if ($urandom_range(0, 1))
			key_pool.push_back('0);
		else
			key_pool.push_back('1);
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				op = OP_PUT;
			else if (pick < 78)
				op = OP_GET;
			else if (pick < 92)
				op = OP_REMOVE;
			else
				op = OP_UNUSED;
			if ($urandom_range(0, 9) == 0)
				k = $urandom();
			else
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			queue_request(op, k, $urandom());
		end
		wait_drained();
	endtask

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i] = '0;
			shadow_data[i] = '0;
			shadow_age[i] = 0;
		end
		shadow_count = 0;
		shadow_capacity = CAP_RESET;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset capacity, hits, misses, update in place, removes, unused code
		idle_odds = 4;
		queue_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		queue_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_request(OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);
		queue_request(OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
		queue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		queue_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_request(OP_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_request(OP_PUT, 32'h0000_0001, 32'h0000_0001);
		queue_request(OP_PUT, 32'h0000_0002, 32'h0000_0002);
		queue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		wait_drained();

		// capacity dropped below the current count: one eviction per insert
		write_capacity(5'd2);
		queue_request(OP_PUT, 32'h0000_0003, 32'h0000_0003);
		queue_request(OP_PUT, 32'h0000_0004, 32'h0000_0004);
		queue_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
		queue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		wait_drained();

		// zero capacity acts as one
		write_capacity(5'd0);
		queue_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
		queue_request(OP_REMOVE, 32'h0000_0003, 32'h0000_0000);
		queue_request(OP_REMOVE, 32'h0000_0004, 32'h0000_0000);
		queue_request(OP_PUT, 32'h8000_0007, 32'h1234_5678);
		queue_request(OP_PUT, 32'h8000_0008, 32'h8765_4321);
		queue_request(OP_GET, 32'h8000_0007, 32'h0000_0000);
		queue_request(OP_GET, 32'h8000_0008, 32'h0000_0000);
		wait_drained();

		idle_odds = 3;
		random_phase(5'd31, 95);
		idle_odds = 0;
		random_phase(5'd16, 95);
		idle_odds = 6;
		random_phase(5'd1, 95);
		idle_odds = 3;
		random_phase(5'd5, 95);
		// long receiver stall while requests keep coming
		hold_requests++;
		random_phase(5'd8, 95);
		idle_odds = 8;
		random_phase(5'd17, 95);
		idle_odds = 2;
		random_phase(CAP_W'($urandom_range(1, 16)), 95);
		idle_odds = 4;
		random_phase(5'd3, 95);
		idle_odds = 0;
		random_phase(5'd16, 95);

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
design/lkvc_pkg.sv
design/lkvc_ctrl.sv
design/lkvc_dp.sv
design/lru_key_value_cache_unit.sv
sim/tb_lru_key_value_cache_unit.sv
